### rtl/core/mtsir_pkg.sv
// Shared types and constants for the machine timer and software interrupt registers.
`timescale 1ns / 1ps

package mtsir_pkg;

  // Operation codes carried in the command transaction.
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;

  // Response status codes.
  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_ADDR_ERR = 1'b1;

  // Register map offsets and access lengths.
  localparam logic [15:0] ADDR_SOFT    = 16'h0000;
  localparam logic [15:0] ADDR_COMPARE = 16'h4000;
  localparam logic [15:0] ADDR_TIME    = 16'hBFF8;
  localparam logic [3:0]  SOFT_LEN     = 4'd4;
  localparam logic [3:0]  MAX_LEN      = 4'd8;
  localparam logic [4:0]  WINDOW_BYTES = 5'd8;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] address;
    logic [3:0]  access_length;
    logic [63:0] write_data;
  } cmd_t;

  typedef struct packed {
    logic [63:0] read_data;
    logic        status;
    logic        software_irq;
    logic        timer_irq;
  } rsp_t;

  typedef struct packed {
    logic        soft_pending;
    logic [63:0] compare_value;
    logic [63:0] time_count;
  } state_t;

endpackage

### rtl/core/mtsir_access.sv
// Address decode, byte-lane read and write merging, and next-state logic for one transaction.
`timescale 1ns / 1ps

module mtsir_access (
  input  mtsir_pkg::cmd_t   cmd,
  input  mtsir_pkg::state_t state,
  output mtsir_pkg::state_t state_next,
  output mtsir_pkg::rsp_t   result
);
  import mtsir_pkg::*;

  logic        len_ok;
  logic        soft_hit;
  logic        cmp_hit;
  logic        time_hit;
  logic [4:0]  slice_end;
  logic [5:0]  lane_shift;
  logic [63:0] len_mask;
  logic [63:0] wr_mask;
  logic [63:0] wr_data;
  logic        is_read;
  logic        is_write;

  // The windows are aligned to eight bytes, so the low address bits give the start byte.
  assign len_ok     = (cmd.access_length != 4'd0) && (cmd.access_length <= MAX_LEN);
  assign slice_end  = {2'b00, cmd.address[2:0]} + {1'b0, cmd.access_length};
  assign lane_shift = {cmd.address[2:0], 3'b000};
  assign soft_hit   = (cmd.address == ADDR_SOFT) && (cmd.access_length == SOFT_LEN);
  assign cmp_hit    = (cmd.address[15:3] == ADDR_COMPARE[15:3]) && (slice_end <= WINDOW_BYTES);
  assign time_hit   = (cmd.address[15:3] == ADDR_TIME[15:3]) && (slice_end <= WINDOW_BYTES);
  assign is_read    = (cmd.operation == OP_READ);
  assign is_write   = (cmd.operation == OP_WRITE);

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      len_mask[i*8 +: 8] = (4'(i) < cmd.access_length) ? 8'hFF : 8'h00;
    end
  end

  assign wr_mask = len_mask << lane_shift;
  assign wr_data = cmd.write_data << lane_shift;

  always_comb begin
    state_next = state;
    result     = '0;
    if (cmd.operation == OP_TICK) begin
      state_next.time_count = state.time_count + 64'd1;
    end else if (is_read || is_write) begin
      if (!len_ok) begin
        result.status = STATUS_ADDR_ERR;
      end else if (soft_hit) begin
        if (is_read) begin
          result.read_data = {63'd0, state.soft_pending};
        end else begin
          state_next.soft_pending = cmd.write_data[0];
        end
      end else if (cmp_hit) begin
        if (is_read) begin
          result.read_data = (state.compare_value >> lane_shift) & len_mask;
        end else begin
          state_next.compare_value = (state.compare_value & ~wr_mask) | (wr_data & wr_mask);
        end
      end else if (time_hit) begin
        // Writes to the time counter are accepted and have no effect.
        if (is_read) begin
          result.read_data = (state.time_count >> lane_shift) & len_mask;
        end
      end else begin
        result.status = STATUS_ADDR_ERR;
      end
    end
    result.software_irq = state_next.soft_pending;
    result.timer_irq    = (state_next.compare_value != 64'd0) &&
                          (state_next.time_count >= state_next.compare_value);
  end

endmodule

### rtl/core/mtsir_regs.sv
// State registers: software pending bit, timer compare value and time counter.
`timescale 1ns / 1ps

module mtsir_regs (
  input  logic              clk,
  input  logic              rst,
  input  logic              update,
  input  mtsir_pkg::state_t state_next,
  output mtsir_pkg::state_t state
);
  import mtsir_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (update) begin
      state <= state_next;
    end
  end

endmodule

### rtl/core/machine_timer_software_irq_regs.sv
// Top level of the core-local timer and software interrupt register block.
`timescale 1ns / 1ps
// Core-local interruptor with a 64-bit time counter, a 64-bit timer compare register
// and a software interrupt bit.
// Command channel (cmd_valid, cmd_stall, cmd): each transaction is a tick, which advances
// the time counter by one, a bus read or a bus write. Reads and writes of the compare and
// time registers may be any byte slice of 1 to 8 bytes that lies within their 8-byte
// window; the software bit is reached only by a 4-byte access at offset zero. Any other
// read or write returns an address error status and changes nothing.
// Response channel (rsp_valid, rsp_stall, rsp): exactly one transaction per command,
// in order, carrying read data, status and the interrupt levels after that command.
// A command accepted at a clock edge is held in the command register, while decode and
// state update feed the response register, whose valid rises at the edge where that
// register takes the result. Throughput is one command per cycle while the receiver
// does not stall.
// While the receiver stalls, the response register holds and one further command may
// wait in the command register; only when both are full is cmd_stall raised.
// Reset clears the interrupt bit, the compare value (which disables the timer) and the
// time counter, and empties both registers.

module machine_timer_software_irq_regs (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  output logic            cmd_stall,
  input  mtsir_pkg::cmd_t cmd,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output mtsir_pkg::rsp_t rsp
);
  import mtsir_pkg::*;

  cmd_t   cmd_held;
  logic   cmd_held_valid;
  logic   rsp_load;
  logic   advance;
  state_t state;
  state_t state_next;
  rsp_t   result;

  // The response register can take a new result when it is empty or being drained.
  assign rsp_load  = !rsp_valid || !rsp_stall;
  // The held command is executed, and state committed, in the cycle its result is stored.
  assign advance   = cmd_held_valid && rsp_load;
  assign cmd_stall = cmd_held_valid && !rsp_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_held_valid <= 1'b0;
      rsp_valid      <= 1'b0;
    end else begin
      if (!cmd_stall) begin
        cmd_held_valid <= cmd_valid;
      end
      if (rsp_load) begin
        rsp_valid <= cmd_held_valid;
      end
    end
  end

  // Payload registers are loaded without reset; their valid flags guard them.
  always_ff @(posedge clk) begin
    if (cmd_valid && !cmd_stall) begin
      cmd_held <= cmd;
    end
    if (advance) begin
      rsp <= result;
    end
  end

  mtsir_access u_access (
    .cmd        (cmd_held),
    .state      (state),
    .state_next (state_next),
    .result     (result)
  );

  mtsir_regs u_regs (
    .clk        (clk),
    .rst        (rst),
    .update     (advance),
    .state_next (state_next),
    .state      (state)
  );

endmodule

### rtl/core/mtsir_checker.sv
// Port-level checks for the timer and software interrupt register block, bound to the top level.
`timescale 1ns / 1ps

module mtsir_checker (
  input logic            clk,
  input logic            rst,
  input logic            cmd_valid,
  input logic            cmd_stall,
  input mtsir_pkg::cmd_t cmd,
  input logic            rsp_valid,
  input logic            rsp_stall,
  input mtsir_pkg::rsp_t rsp
);
  import mtsir_pkg::*;

  // A stalled response transaction is held unchanged.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled response changed");

  // With the response side empty, a command is never stalled.
  assert property (@(posedge clk) disable iff (rst)
    !rsp_valid |-> !cmd_stall)
    else $error("command stalled while response register empty");

  // An address error never returns read data.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == STATUS_ADDR_ERR) |-> (rsp.read_data == 64'd0))
    else $error("address error with nonzero read data");

  // Reset leaves no response pending.
  assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid after reset");

  // With no command offered, no new response follows unless one was already waiting.
  assert property (@(posedge clk) disable iff (rst)
    !rsp_valid && !cmd_valid |=> ##1 !(rsp_valid && !$past(rsp_valid) && !$past(cmd_valid, 2)))
    else $error("response without command");

endmodule

bind machine_timer_software_irq_regs mtsir_checker u_checker (.*);

### test/machine_timer_software_irq_regs_test.sv
// Self-checking testbench for the timer and software interrupt register block.
`timescale 1ns / 1ps

module machine_timer_software_irq_regs_test;
  import mtsir_pkg::*;

  // A queued command, with a flag that makes the sender wait for every
  // outstanding response before it offers this one.
  typedef struct packed {
    logic drain;
    cmd_t c;
  } queued_cmd_t;

  // Receiver behaviour; the modes take turns in a fixed order.
  typedef enum logic [1:0] {
    RX_FREE,
    RX_LIGHT,
    RX_HEAVY,
    RX_PERIODIC
  } rx_mode_t;

  localparam int RANDOM_ITEMS = 1250;
  localparam int QUIET_LIMIT  = 2000;
  localparam int HOLD_OFF_LEN = 90;
  localparam int HOLD_OFF_AT  = 400;

  // The one operation code that the block treats as doing nothing.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic clk;
  logic rst;
  logic cmd_valid;
  logic cmd_stall;
  cmd_t cmd;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp;

  machine_timer_software_irq_regs dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  // Commands waiting to be offered, and responses predicted for commands
  // that the block has already taken, oldest first.
  queued_cmd_t command_backlog[$];
  rsp_t        awaited_responses[$];

  // Our own copy of the block's architectural state.
  logic        mdl_soft;
  logic [63:0] mdl_compare;
  logic [63:0] mdl_time;

  // Tick count as seen while building the stimulus; used only to aim compare
  // values close to the running time so that the timer interrupt toggles.
  logic [63:0] planned_time;

  int unsigned burst_left;
  int unsigned gap_left;
  int unsigned rx_cycle;
  int unsigned hold_left;
  bit          hold_done;
  int unsigned quiet_cycles;

  int unsigned responses_seen;
  int unsigned mismatches;
  int unsigned ticks_taken;
  int unsigned reads_taken;
  int unsigned writes_taken;
  int unsigned others_taken;
  int unsigned addr_errors_seen;
  int unsigned timer_high_seen;

  // The clock runs with a 12 ns period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Mask covering the low len bytes of a 64-bit word.
  function automatic logic [63:0] lane_mask(logic [3:0] len);
    return (len >= MAX_LEN) ? '1 : ((64'd1 << {len, 3'b000}) - 64'd1);
  endfunction

  // Applies one command to the predicted state and returns the response the
  // block should give for it. The interrupt levels are taken after the update.
  function automatic rsp_t predict_response(cmd_t c);
    rsp_t        r;
    logic [16:0] span_end;
    logic [5:0]  shift;
    logic [63:0] mask;
    r        = '0;
    span_end = {1'b0, c.address} + 17'(c.access_length);
    shift    = {c.address[2:0], 3'b000};
    mask     = lane_mask(c.access_length);
    if (c.operation == OP_TICK) begin
      mdl_time = mdl_time + 64'd1;
    end else if (c.operation == OP_READ || c.operation == OP_WRITE) begin
      if (c.access_length == 4'd0 || c.access_length > MAX_LEN) begin
        r.status = STATUS_ADDR_ERR;
      end else if (c.address == ADDR_SOFT && c.access_length == SOFT_LEN) begin
        if (c.operation == OP_READ) begin
          r.read_data = {63'd0, mdl_soft};
        end else begin
          mdl_soft = c.write_data[0];
        end
      end else if (c.address >= ADDR_COMPARE &&
                   span_end <= ADDR_COMPARE + WINDOW_BYTES) begin
        // Both windows are 8-byte aligned, so the slice starts at the low
        // three address bits.
        if (c.operation == OP_READ) begin
          r.read_data = (mdl_compare >> shift) & mask;
        end else begin
          mdl_compare = (mdl_compare & ~(mask << shift)) |
                        ((c.write_data << shift) & (mask << shift));
        end
      end else if (c.address >= ADDR_TIME && span_end <= ADDR_TIME + WINDOW_BYTES) begin
        // The time counter is read-only; writes are taken and dropped.
        if (c.operation == OP_READ) begin
          r.read_data = (mdl_time >> shift) & mask;
        end
      end else begin
        r.status = STATUS_ADDR_ERR;
      end
    end
    // The unused operation code falls through with no effect and a clean status.
    r.software_irq = mdl_soft;
    r.timer_irq    = (mdl_compare != 64'd0) && (mdl_time >= mdl_compare);
    return r;
  endfunction

  task automatic add_cmd(input logic [1:0] op, input logic [15:0] addr,
                         input logic [3:0] len, input logic [63:0] data,
                         input logic drain);
    queued_cmd_t q;
    q.drain           = drain;
    q.c.operation     = op;
    q.c.address       = addr;
    q.c.access_length = len;
    q.c.write_data    = data;
    command_backlog.push_back(q);
    if (op == OP_TICK) begin
      planned_time = planned_time + 64'd1;
    end
  endtask

  // Builds the whole stimulus up front, then waits for the run to drain and
  // reports the verdict.
  initial begin : stimulus
    int unsigned pick;
    int unsigned start;
    int unsigned len;
    logic [1:0]  op;
    logic [15:0] addr;
    logic [63:0] data;

    rst          = 1'b1;
    cmd_valid    = 1'b0;
    cmd          = '0;
    rsp_stall    = 1'b0;
    mdl_soft     = 1'b0;
    mdl_compare  = '0;
    mdl_time     = '0;
    planned_time = '0;
    burst_left   = 1;
    gap_left     = 0;

    // Directed opening: the software bit and its exact-length rule, both
    // register windows at their edges, lengths of zero and over eight, write
    // bytes past the access length, the ignored time write, the unused
    // operation code and the timer interrupt rising and being disabled.
    add_cmd(OP_READ,  ADDR_SOFT, SOFT_LEN, '0, 1'b0);
    add_cmd(OP_WRITE, ADDR_SOFT, SOFT_LEN, '1, 1'b0);
    add_cmd(OP_READ,  ADDR_SOFT, SOFT_LEN, '0, 1'b0);
    add_cmd(OP_WRITE, ADDR_SOFT, SOFT_LEN, 64'hFFFF_FFFF_FFFF_FFFE, 1'b0);
    add_cmd(OP_WRITE, ADDR_SOFT, SOFT_LEN, 64'd1, 1'b0);
    add_cmd(OP_READ,  ADDR_SOFT, MAX_LEN, '0, 1'b0);
    add_cmd(OP_READ,  ADDR_COMPARE, 4'd0, '0, 1'b0);
    add_cmd(OP_READ,  ADDR_COMPARE, 4'd15, '0, 1'b0);
    add_cmd(OP_WRITE, ADDR_COMPARE, MAX_LEN, '1, 1'b0);
    add_cmd(OP_READ,  ADDR_COMPARE + 16'd7, 4'd1, '0, 1'b0);
    add_cmd(OP_READ,  ADDR_COMPARE + 16'd3, 4'd2, '0, 1'b0);
    add_cmd(OP_WRITE, ADDR_COMPARE + 16'd7, 4'd2, '0, 1'b0);
    add_cmd(OP_READ,  ADDR_COMPARE - 16'd1, 4'd2, '0, 1'b0);
    add_cmd(OP_WRITE, ADDR_COMPARE, MAX_LEN, '0, 1'b0);
    add_cmd(OP_WRITE, ADDR_COMPARE, 4'd1, 64'hFFFF_FFFF_FFFF_FF04, 1'b0);
    repeat (4) add_cmd(OP_TICK, '0, '0, '0, 1'b0);
    add_cmd(OP_READ,  ADDR_TIME, MAX_LEN, '0, 1'b0);
    add_cmd(OP_WRITE, ADDR_TIME, MAX_LEN, '1, 1'b0);
    add_cmd(OP_READ,  ADDR_TIME + 16'd7, 4'd1, '0, 1'b0);
    add_cmd(OP_READ,  ADDR_TIME + 16'd4, MAX_LEN, '0, 1'b0);
    add_cmd(OP_READ,  16'hFFFF, 4'd1, '0, 1'b0);
    add_cmd(OP_UNUSED, 16'hFFFF, 4'd15, '1, 1'b0);
    add_cmd(OP_WRITE, ADDR_COMPARE, MAX_LEN, '0, 1'b1);

    // Random part. Most commands are legal accesses with random slices and
    // data, with ticks frequent enough and compare values aimed near the
    // running time so that the timer interrupt rises and falls often. The
    // rest are near misses around the windows and unconstrained noise.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      pick = $urandom_range(0, 99);
      data = {$urandom, $urandom};
      if (pick < 35) begin
        add_cmd(OP_TICK, 16'($urandom), 4'($urandom), data, 1'b0);
      end else if (pick < 50) begin
        case ($urandom_range(0, 3))
          0: add_cmd(OP_WRITE, ADDR_COMPARE, MAX_LEN,
                     planned_time + 64'($urandom_range(0, 16)) - 64'd4, 1'b0);
          1: add_cmd(OP_WRITE, ADDR_COMPARE, MAX_LEN,
                     ($urandom_range(0, 1) == 0) ? 64'd0 : data, 1'b0);
          default: begin
            start = $urandom_range(0, 7);
            len   = $urandom_range(1, 8 - start);
            add_cmd(OP_WRITE, ADDR_COMPARE + 16'(start), 4'(len), data, 1'b0);
          end
        endcase
      end else if (pick < 62) begin
        start = $urandom_range(0, 7);
        len   = $urandom_range(1, 8 - start);
        add_cmd(OP_READ, ADDR_COMPARE + 16'(start), 4'(len), data, 1'b0);
      end else if (pick < 78) begin
        start = $urandom_range(0, 7);
        len   = $urandom_range(1, 8 - start);
        op    = (pick < 72) ? OP_READ : OP_WRITE;
        add_cmd(op, ADDR_TIME + 16'(start), 4'(len), data, 1'b0);
      end else if (pick < 86) begin
        op = ($urandom_range(0, 1) == 0) ? OP_READ : OP_WRITE;
        add_cmd(op, ADDR_SOFT, SOFT_LEN, data, 1'b0);
      end else if (pick < 92) begin
        op = ($urandom_range(0, 1) == 0) ? OP_READ : OP_WRITE;
        case ($urandom_range(0, 4))
          0: begin
            addr = ADDR_SOFT + 16'($urandom_range(0, 3));
            len  = $urandom_range(1, 8);
          end
          1: begin
            start = $urandom_range(1, 7);
            addr  = ADDR_COMPARE + 16'(start);
            len   = $urandom_range(9 - start, 8);
          end
          2: begin
            start = $urandom_range(1, 7);
            addr  = ADDR_TIME + 16'(start);
            len   = $urandom_range(9 - start, 8);
          end
          3: begin
            case ($urandom_range(0, 3))
              0: addr = ADDR_COMPARE - 16'd1;
              1: addr = ADDR_COMPARE + 16'd8;
              2: addr = ADDR_TIME - 16'd1;
              default: addr = ADDR_TIME + 16'd8;
            endcase
            len = $urandom_range(1, 8);
          end
          default: begin
            addr = ($urandom_range(0, 1) == 0) ? ADDR_COMPARE : ADDR_TIME;
            len  = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(9, 15);
          end
        endcase
        add_cmd(op, addr, 4'(len), data, 1'b0);
      end else begin
        add_cmd(2'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)),
                4'($urandom_range(0, 15)), data, 1'b0);
      end
      // Now and then the sender lets the block run completely dry.
      if (i == 300 || i == 700 || i == 1000) begin
        command_backlog[command_backlog.size() - 1].drain = 1'b1;
      end
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (command_backlog.size() != 0 || cmd_valid) @(posedge clk);
    while (awaited_responses.size() != 0) @(posedge clk);
    // Wait on so that any spurious response still shows up.
    repeat (10) @(posedge clk);

    $display("Checked %0d responses to %0d ticks, %0d reads, %0d writes and %0d unused codes.",
             responses_seen, ticks_taken, reads_taken, writes_taken, others_taken);
    $display("Saw %0d address errors and %0d responses with the timer interrupt high.",
             addr_errors_seen, timer_high_seen);
    if (mismatches == 0) begin
      $display("machine_timer_software_irq_regs regression: pass");
    end else begin
      $display("machine_timer_software_irq_regs regression: fail");
    end
    $finish;
  end

  // Sender. It offers commands in bursts of random length separated by short
  // random gaps, holds a stalled transaction unchanged, and predicts the
  // response at the edge where a command is taken.
  always @(posedge clk) begin : drive
    logic        offer;
    queued_cmd_t item;
    offer = cmd_valid;
    if (rst) begin
      offer = 1'b0;
    end else begin
      if (cmd_valid && !cmd_stall) begin
        awaited_responses.push_back(predict_response(cmd));
        case (cmd.operation)
          OP_TICK:  ticks_taken++;
          OP_READ:  reads_taken++;
          OP_WRITE: writes_taken++;
          default:  others_taken++;
        endcase
        offer = 1'b0;
      end
      if (!offer) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (command_backlog.size() != 0 &&
                     !(command_backlog[0].drain && awaited_responses.size() != 0)) begin
          item = command_backlog.pop_front();
          cmd <= item.c;
          offer = 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 48);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
          end else begin
            burst_left--;
          end
        end
      end
    end
    cmd_valid <= offer;
  end

  // Receiver. Each accepted response is checked against the oldest
  // prediction. The stall pattern steps through its modes in turn, and once, after a
  // few hundred responses, the receiver holds off long enough for the block
  // to fill and stall its command side.
  always @(posedge clk) begin : observe
    rsp_t want;
    logic hold_now;
    if (!rst && rsp_valid && !rsp_stall) begin
      responses_seen++;
      if (rsp.status === STATUS_ADDR_ERR) addr_errors_seen++;
      if (rsp.timer_irq === 1'b1) timer_high_seen++;
      if (awaited_responses.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: response with nothing outstanding: rd=%h st=%b sw=%b tm=%b",
                   $realtime, rsp.read_data, rsp.status, rsp.software_irq, rsp.timer_irq);
        end
      end else begin
        want = awaited_responses.pop_front();
        if (rsp.read_data !== want.read_data || rsp.status !== want.status ||
            rsp.software_irq !== want.software_irq || rsp.timer_irq !== want.timer_irq) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: response %0d expected rd=%h st=%b sw=%b tm=%b",
                     $realtime, responses_seen, want.read_data, want.status,
                     want.software_irq, want.timer_irq);
            $display("%0t: response %0d got      rd=%h st=%b sw=%b tm=%b",
                     $realtime, responses_seen, rsp.read_data, rsp.status,
                     rsp.software_irq, rsp.timer_irq);
          end
        end
      end
    end

    hold_now = 1'b0;
    if (!rst) begin
      rx_cycle++;
      if (hold_left != 0) begin
        hold_left--;
        hold_now = 1'b1;
      end else if (!hold_done && responses_seen >= HOLD_OFF_AT) begin
        hold_left = HOLD_OFF_LEN;
        hold_done = 1'b1;
        hold_now  = 1'b1;
      end else begin
        case (rx_mode_t'((rx_cycle / 97) % 4))
          RX_FREE:  hold_now = 1'b0;
          RX_LIGHT: hold_now = ($urandom_range(0, 3) == 0);
          RX_HEAVY: hold_now = ($urandom_range(0, 3) != 0);
          default:  hold_now = ((rx_cycle % 5) < 2);
        endcase
      end
    end
    rsp_stall <= hold_now;
  end

  // Watchdog. A healthy run never goes this long without a transaction on
  // either channel, so a stretch this quiet means the block has hung.
  always @(posedge clk) begin
    if (rst || (cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timed out after %0d cycles without a transaction.", quiet_cycles);
      $display("machine_timer_software_irq_regs regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

### filelist.f
rtl/core/mtsir_pkg.sv
rtl/core/mtsir_access.sv
rtl/core/mtsir_regs.sv
rtl/core/machine_timer_software_irq_regs.sv
rtl/core/mtsir_checker.sv
test/machine_timer_software_irq_regs_test.sv
